// ----- hdl/wsd_pkg.sv -----
package wsd_pkg;

    localparam int WINDOW_DEPTH_DEF   = 64;
    localparam int CHECK_INTERVAL_DEF = 16;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_END    = 2'd2,
        OP_UNUSED = 2'd3
    } wsd_op_t;

    // battery thresholds
    localparam logic [7:0] BAT_FULL  = 8'h8d;
    localparam logic [7:0] BAT_HIGH  = 8'h7d;
    localparam logic [7:0] BAT_MID   = 8'h78;
    localparam logic [7:0] BAT_LOW   = 8'h6A;

    // q16 temperature factor = (999 * 65536 * k + 5e6) / 1e7, k = 10000 - 7*d
    // = 6*k + (42738*k + 39062) / 78125, quotient by reciprocal multiply
    // (multiply by ceil(2^46 / 78125), keep bits 58:46, exact for the range of k)
    localparam logic [2:0]  FAC_INT      = 3'd6;
    localparam logic [15:0] FAC_FRAC_MUL = 16'd42738;
    localparam logic [15:0] FAC_FRAC_ADD = 16'd39062;
    localparam logic [29:0] FAC_RECIP    = 30'd900719926;
    localparam logic [14:0] K_BASE       = 15'd10000;
    localparam logic [15:0] Q16_HALF     = 16'd32768;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  battery_raw;
        logic [7:0]  ref_temp;
        logic [7:0]  board_temp;
        logic [16:0] load_top_right;
        logic [16:0] load_bottom_right;
        logic [16:0] load_top_left;
        logic [16:0] load_bottom_left;
    } wsd_in_t;

    typedef struct packed {
        logic        is_report;
        logic        weight_locked;
        logic [19:0] weight_g;
        logic        telemetry_valid;
        logic [6:0]  battery_pct;
        logic [7:0]  ref_temp_out;
        logic [7:0]  temp_out;
    } wsd_out_t;

    typedef struct packed {
        logic        done;
        logic        lock;
        logic [19:0] mean;
    } wsd_chk_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WEIGHT,
        ST_WINDOW,
        ST_OUT
    } wsd_st_t;

    typedef enum logic [2:0] {
        WS_IDLE,
        WS_SCAN,
        WS_SQ_LO,
        WS_SQ_HI,
        WS_CMP
    } wsd_wst_t;

    function automatic logic [6:0] battery_pct_f(input logic [7:0] raw);
        logic [6:0] pct;
        if (raw >= BAT_FULL)
            pct = 7'd100;
        else if (raw >= BAT_HIGH)
            pct = 7'd75;
        else if (raw >= BAT_MID)
            pct = 7'd50;
        else if (raw >= BAT_LOW)
            pct = 7'd25;
        else
            pct = 7'd0;
        return pct;
    endfunction

endpackage

// ----- hdl/wsd_stream_if.sv -----
interface wsd_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/wsd_weight.sv -----
module wsd_weight
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [7:0]  board_temp,
    input  logic [7:0]  ref_temp,
    input  logic [18:0] load_sum,
    output logic        done,
    output logic [19:0] weight
);

    localparam logic [2:0] CYC_FRAC  = 3'd1;
    localparam logic [2:0] CYC_RECIP = 3'd2;
    localparam logic [2:0] CYC_FACT  = 3'd3;
    localparam logic [2:0] CYC_MUL_W = 3'd4;
    localparam logic [2:0] CYC_DONE  = 3'd5;

    logic [2:0]         cyc_reg, cyc_next;
    logic [28:0]        frac_reg;
    logic [16:0]        k6_reg;
    logic [58:0]        recip_reg;
    logic [16:0]        factor_reg;
    logic [36:0]        prod_reg;
    logic signed [8:0]  diff;
    logic signed [14:0] diff_x;
    logic [13:0]        k_val;

    always_comb
    begin
        diff   = $signed({1'b0, board_temp}) - $signed({1'b0, ref_temp});
        diff_x = 15'(diff) * 15'sd7;
        k_val  = 14'($signed(K_BASE) - diff_x);
    end

    always_comb
    begin
        if (cyc_reg == '0)
            cyc_next = start ? CYC_FRAC : '0;
        else if (cyc_reg == CYC_DONE)
            cyc_next = '0;
        else
            cyc_next = cyc_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cyc_reg <= '0;
        else
            cyc_reg <= cyc_next;
    end

    // factor pipeline: fractional numerator, reciprocal multiply, add, weight
    always_ff @(posedge clk)
    begin
        if (cyc_reg == CYC_FRAC)
        begin
            frac_reg <= 29'(30'(k_val) * 30'(FAC_FRAC_MUL) + 30'(FAC_FRAC_ADD));
            k6_reg   <= 17'(k_val) * 17'(FAC_INT);
        end
        if (cyc_reg == CYC_RECIP)
            recip_reg <= 59'(frac_reg) * 59'(FAC_RECIP);
        if (cyc_reg == CYC_FACT)
            factor_reg <= k6_reg + 17'(recip_reg[58:46]);
        if (cyc_reg == CYC_MUL_W)
            prod_reg <= 37'(37'(load_sum) * 37'(factor_reg)) + 37'(Q16_HALF);
    end

    assign done   = cyc_reg == CYC_DONE;
    assign weight = prod_reg[36] ? '1 : prod_reg[35:16];

endmodule

// ----- hdl/wsd_window.sv -----
module wsd_window
    import wsd_pkg::*;
#(
    parameter int WINDOW_DEPTH   = WINDOW_DEPTH_DEF,
    parameter int CHECK_INTERVAL = CHECK_INTERVAL_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        wr,
    input  logic [19:0] wr_value,
    input  logic [15:0] dev_limit,
    input  logic [19:0] min_weight,
    output wsd_chk_t    chk
);

    localparam int AW  = $clog2(WINDOW_DEPTH);
    localparam int SW  = 20 + AW;
    localparam int QW  = 40 + AW;
    localparam int CW  = 2 * SW;
    localparam int HW  = (SW + 1) / 2;
    localparam int ICW = (CHECK_INTERVAL > 1) ? $clog2(CHECK_INTERVAL) : 1;

    wsd_wst_t st_reg, st_next;

    logic [19:0]        mem [WINDOW_DEPTH];
    logic [19:0]        rdata_reg;
    logic [AW-1:0]      pos_reg;
    logic               full_reg;
    logic [ICW-1:0]     icnt_reg;
    logic [AW:0]        rd_cnt_reg;
    logic               p1_reg, p2_reg;
    logic [19:0]        v_reg;
    logic [39:0]        sq_reg;
    logic [SW-1:0]      s_reg;
    logic [QW-1:0]      q_reg;
    logic [SW+HW-1:0]   pp_lo_reg;
    logic [2*SW-HW-1:0] pp_hi_reg;
    logic [31:0]        lim_reg;
    logic [31+AW:0]     limn_reg;
    logic               done_reg, lock_reg;
    logic [19:0]        mean_reg;

    logic           wrap;
    logic [AW-1:0]  pos_nx;
    logic [ICW-1:0] icnt_nx;
    logic           do_chk;
    logic           issue, scan_init, scan_end;
    logic [CW-1:0]  ss, nq, dv, lim_cmp;
    logic           heavy, tight;

    always_comb
    begin
        wrap    = pos_reg == AW'(WINDOW_DEPTH - 1);
        pos_nx  = wrap ? '0 : pos_reg + 1'b1;
        if (wrap || icnt_reg == ICW'(CHECK_INTERVAL - 1))
            icnt_nx = '0;
        else
            icnt_nx = icnt_reg + 1'b1;
        do_chk  = (full_reg || wrap) && icnt_nx == '0;
        ss      = (CW'(pp_hi_reg) << HW) + CW'(pp_lo_reg);
        nq      = CW'(q_reg) << AW;
        dv      = nq - ss;
        lim_cmp = CW'(limn_reg) << AW;
        heavy   = s_reg > (SW'(min_weight) << AW);
        tight   = dv < lim_cmp;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            WS_IDLE:  if (wr && do_chk) st_next = WS_SCAN;
            WS_SCAN:  if (scan_end) st_next = WS_SQ_LO;
            WS_SQ_LO: st_next = WS_SQ_HI;
            WS_SQ_HI: st_next = WS_CMP;
            WS_CMP:   st_next = WS_IDLE;
            default:  st_next = WS_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        issue     = 1'b0;
        scan_init = 1'b0;
        scan_end  = 1'b0;
        case (st_reg)
            WS_IDLE: scan_init = wr && do_chk;
            WS_SCAN:
            begin
                issue    = !rd_cnt_reg[AW];
                scan_end = rd_cnt_reg[AW] && !p1_reg && !p2_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= WS_IDLE;
            pos_reg    <= '0;
            full_reg   <= 1'b0;
            icnt_reg   <= '0;
            rd_cnt_reg <= '0;
            p1_reg     <= 1'b0;
            p2_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (clear)
            begin
                pos_reg  <= '0;
                full_reg <= 1'b0;
                icnt_reg <= '0;
            end
            else if (wr)
            begin
                pos_reg  <= pos_nx;
                full_reg <= full_reg || wrap;
                icnt_reg <= icnt_nx;
            end
            if (scan_init)
                rd_cnt_reg <= '0;
            else if (issue)
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            p1_reg   <= issue;
            p2_reg   <= p1_reg;
            done_reg <= (st_reg == WS_IDLE && wr && !do_chk) || st_reg == WS_CMP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[pos_reg] <= wr_value;
        rdata_reg <= mem[rd_cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (p1_reg)
        begin
            sq_reg <= 40'(rdata_reg) * 40'(rdata_reg);
            v_reg  <= rdata_reg;
        end
        if (scan_init)
        begin
            s_reg <= '0;
            q_reg <= '0;
        end
        else if (p2_reg)
        begin
            s_reg <= s_reg + SW'(v_reg);
            q_reg <= q_reg + QW'(sq_reg);
        end
        if (st_reg == WS_SQ_LO)
        begin
            pp_lo_reg <= (SW + HW)'(s_reg) * (SW + HW)'(s_reg[HW-1:0]);
            lim_reg   <= 32'(dev_limit) * 32'(dev_limit);
        end
        if (st_reg == WS_SQ_HI)
        begin
            pp_hi_reg <= (2 * SW - HW)'(s_reg) * (2 * SW - HW)'(s_reg[SW-1:HW]);
            limn_reg  <= (32 + AW)'(lim_reg) * (32 + AW)'(WINDOW_DEPTH - 1);
        end
        if (st_reg == WS_IDLE && wr)
            lock_reg <= 1'b0;
        else if (st_reg == WS_CMP)
        begin
            lock_reg <= heavy && tight;
            mean_reg <= 20'((s_reg + SW'(WINDOW_DEPTH / 2)) >> AW);
        end
    end

    assign chk.done = done_reg;
    assign chk.lock = lock_reg;
    assign chk.mean = mean_reg;

`ifndef SYNTH
    a_scan_only_full : assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == WS_IDLE && st_next == WS_SCAN) |-> (full_reg || wrap))
        else $error("window check started before the window filled");
    a_no_write_busy : assert property (@(posedge clk) disable iff (!rst_n)
        wr |-> st_reg == WS_IDLE)
        else $error("window write during a check");
    a_scan_count : assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == WS_SCAN && st_next == WS_SQ_LO) |-> rd_cnt_reg[AW])
        else $error("check finished before every entry was read");
`endif

endmodule

// ----- hdl/weight_stability_detector_top.sv -----
// Weight stability detector. Takes start, sample and end words on in_ch
// and gives exactly one status word on out_ch for each of them. A sample
// with a nonzero reference temperature, while no weight is locked, stores
// the battery level and temperatures, sums the four corner loads, scales
// the sum by the q16 temperature factor and, when the result reaches
// min_weight_g, writes it into a WINDOW_DEPTH-entry window held in a
// synchronous memory. Once the window has filled, every CHECK_INTERVAL-th
// write walks the whole memory for sum and sum of squares and locks the
// rounded mean when it is heavy enough and its variance is under
// deviation_limit_g squared. An end word reports the session as it stood
// and then clears it. A weighed sample passes through the factor and
// weight pipeline (numerator multiply, reciprocal multiply, factor add,
// weight multiply); a sample that triggers a check then reads the window
// entries one at a time through the single read port of the window
// memory. Stalls on out_ch hold a word in its output state. WINDOW_DEPTH
// must be a power of two. The window memory is not cleared; it is only
// read after it has been filled. A new word is accepted while the last
// status word still waits on out_ch. Registers: deviation_limit_g at byte
// address 0, min_weight_g at byte address 4.
module weight_stability_detector_top
    import wsd_pkg::*;
#(
    parameter int WINDOW_DEPTH   = WINDOW_DEPTH_DEF,
    parameter int CHECK_INTERVAL = CHECK_INTERVAL_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    wsd_stream_if.sink   in_ch,
    wsd_stream_if.source out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    wsd_st_t st_reg, st_next;

    // configuration registers
    logic [15:0] dev_reg;
    logic [19:0] min_reg;

    // latched input word
    wsd_in_t in_reg;

    // session state
    logic        locked_reg;
    logic [19:0] locked_wt_reg;
    logic [7:0]  ref_reg;
    logic [7:0]  temp_reg;
    logic [6:0]  bat_reg;

    // output slot
    logic     out_valid_reg;
    wsd_out_t out_data_reg;

    logic        accept;
    logic        ignore;
    logic        out_free;
    logic        heavy;
    logic [18:0] load_sum;
    logic        w_done;
    logic [19:0] w_value;
    wsd_chk_t    chk;
    wsd_out_t    result;

    // control from the sequencer
    logic in_ready, wt_start, sess_clear, win_wr, lock_load, out_load;

    assign accept   = in_ch.valid && in_ready;
    assign ignore   = in_ch.data.ref_temp == '0 || locked_reg;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign heavy    = w_value >= min_reg;
    assign load_sum = 19'(in_reg.load_top_right) + 19'(in_reg.load_bottom_right)
                    + 19'(in_reg.load_top_left) + 19'(in_reg.load_bottom_left);

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_ch.data.opcode == OP_SAMPLE && !ignore)
                        st_next = ST_WEIGHT;
                    else
                        st_next = ST_OUT;
                end
            end
            ST_WEIGHT: if (w_done) st_next = heavy ? ST_WINDOW : ST_OUT;
            ST_WINDOW: if (chk.done) st_next = ST_OUT;
            ST_OUT:    if (out_free) st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready   = 1'b0;
        wt_start   = 1'b0;
        sess_clear = 1'b0;
        win_wr     = 1'b0;
        lock_load  = 1'b0;
        out_load   = 1'b0;
        case (st_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                wt_start   = accept && in_ch.data.opcode == OP_SAMPLE && !ignore;
                sess_clear = accept && in_ch.data.opcode == OP_START;
            end
            ST_WEIGHT: win_wr = w_done && heavy;
            ST_WINDOW: lock_load = chk.done && chk.lock;
            ST_OUT:
            begin
                out_load   = out_free;
                // the report shows the session before it is cleared
                sess_clear = out_free && in_reg.opcode == OP_END;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.is_report       = in_reg.opcode == OP_END;
        result.weight_locked   = locked_reg;
        result.weight_g        = locked_wt_reg;
        result.telemetry_valid = ref_reg != '0;
        result.battery_pct     = bat_reg;
        result.ref_temp_out    = ref_reg;
        result.temp_out        = temp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            dev_reg       <= 16'd400;
            min_reg       <= 20'd10000;
            locked_reg    <= 1'b0;
            locked_wt_reg <= '0;
            ref_reg       <= '0;
            temp_reg      <= '0;
            bat_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (psel && penable && pwrite)
            begin
                if (paddr[2])
                    min_reg <= pwdata[19:0];
                else
                    dev_reg <= pwdata[15:0];
            end
            if (sess_clear)
            begin
                locked_reg    <= 1'b0;
                locked_wt_reg <= '0;
                ref_reg       <= '0;
                temp_reg      <= '0;
                bat_reg       <= '0;
            end
            else
            begin
                if (wt_start)
                begin
                    ref_reg  <= in_ch.data.ref_temp;
                    temp_reg <= in_ch.data.board_temp;
                    bat_reg  <= battery_pct_f(in_ch.data.battery_raw);
                end
                if (lock_load)
                begin
                    locked_reg    <= 1'b1;
                    locked_wt_reg <= chk.mean;
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_reg <= in_ch.data;
        if (out_load)
            out_data_reg <= result;
    end

    wsd_weight u_weight (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (wt_start),
        .board_temp (in_reg.board_temp),
        .ref_temp   (in_reg.ref_temp),
        .load_sum   (load_sum),
        .done       (w_done),
        .weight     (w_value)
    );

    wsd_window #(
        .WINDOW_DEPTH   (WINDOW_DEPTH),
        .CHECK_INTERVAL (CHECK_INTERVAL)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (sess_clear),
        .wr         (win_wr),
        .wr_value   (w_value),
        .dev_limit  (dev_reg),
        .min_weight (min_reg),
        .chk        (chk)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;
    assign prdata       = paddr[2] ? 32'(min_reg) : 32'(dev_reg);
    assign pready       = 1'b1;

`ifndef SYNTH
    a_wdone_state : assert property (@(posedge clk) disable iff (!rst_n)
        w_done |-> st_reg == ST_WEIGHT)
        else $error("weight finished outside the weight phase");
    a_chk_state : assert property (@(posedge clk) disable iff (!rst_n)
        chk.done |-> st_reg == ST_WINDOW)
        else $error("window check finished outside the window phase");
    a_unlock_clear : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(locked_reg) |-> $past(sess_clear))
        else $error("lock dropped without a session clear");
    a_weight_locked : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.weight_g == '0 || out_data_reg.weight_locked))
        else $error("weight reported without a lock");
`endif

endmodule
